@@ hdl/hpgf_pkg.sv @@
// ============================================================================
// hpgf_pkg: shared types and constants for the harmonic phase gap fill
// Payload structs, sizing constants and the request bundle that the sequencer
// hands to the shared interpolation divider.
// ============================================================================
package hpgf_pkg;

    // Frames per table and the width of a frame index.
    localparam int FRAME_LIMIT = 64;
    localparam int FRAME_W     = $clog2(FRAME_LIMIT);

    // Q1.15 vector component and amplitude widths.
    localparam int VEC_W = 16;
    localparam int AMP_W = 16;

    // Divider sizing: magnitude times frame step, doubled, plus the divisor.
    localparam int MAG_W  = VEC_W;
    localparam int PROD_W = MAG_W + FRAME_W;
    localparam int DVD_W  = PROD_W + 1;
    localparam int DSR_W  = FRAME_W + 1;
    localparam int REM_W  = DSR_W + 1;
    localparam int CNT_W  = $clog2(DVD_W);

    // Reset value of the threshold and the saturated value of 1.0 in Q1.15.
    localparam logic [AMP_W-1:0] THRESHOLD_RESET = AMP_W'(3277);
    localparam logic signed [VEC_W-1:0] Q15_ONE  = VEC_W'(32767);

    // One input frame.
    typedef struct packed {
        logic [AMP_W-1:0]        amplitude;
        logic signed [VEC_W-1:0] vector_re;
        logic signed [VEC_W-1:0] vector_im;
        logic                    is_last_frame;
    } hpgf_in_t;

    // One settled frame.
    typedef struct packed {
        logic [5:0]              frame_number;
        logic signed [VEC_W-1:0] out_re;
        logic signed [VEC_W-1:0] out_im;
        logic                    end_of_run;
    } hpgf_out_t;

    // Request to the interpolation unit for one component.
    typedef struct packed {
        logic                    start;
        logic signed [VEC_W-1:0] from_val;
        logic signed [VEC_W-1:0] to_val;
        logic [FRAME_W-1:0]      num;
        logic [FRAME_W-1:0]      den;
    } hpgf_div_req_t;

endpackage

@@ hdl/hpgf_interp.sv @@
// ============================================================================
// hpgf_interp: one component of a linear phase interpolation
// Computes from + round((to - from) * num / den), ties away from zero, with a
// multiply step followed by a bit-serial restoring divider.
// ============================================================================
module hpgf_interp
    import hpgf_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  hpgf_div_req_t           req,
    output logic                    done,
    output logic signed [VEC_W-1:0] result
);

    localparam logic [1:0] I_IDLE = 2'd0;
    localparam logic [1:0] I_MUL  = 2'd1;
    localparam logic [1:0] I_DIV  = 2'd2;
    localparam logic [1:0] I_FIN  = 2'd3;

    logic [1:0]              state_reg, state_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic signed [VEC_W-1:0] from_reg;
    logic                    neg_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [FRAME_W-1:0]      num_reg;
    logic [FRAME_W-1:0]      den_reg;
    logic [DVD_W-1:0]        dvd_reg, dvd_next;
    logic [DSR_W-1:0]        rem_reg, rem_next;

    logic signed [VEC_W:0]   delta;
    logic [VEC_W:0]          delta_abs;
    logic [PROD_W-1:0]       prod;
    logic [DSR_W-1:0]        dsr;
    logic [REM_W-1:0]        rem_sh;
    logic                    qbit;
    logic signed [VEC_W+1:0] from_ext;
    logic signed [VEC_W+1:0] quo_ext;
    logic signed [VEC_W+1:0] sum;

    // Difference and its magnitude; the magnitude never exceeds 16 bits.
    assign delta     = {req.to_val[VEC_W-1], req.to_val} - {req.from_val[VEC_W-1], req.from_val};
    assign delta_abs = delta[VEC_W] ? (VEC_W+1)'(-delta) : (VEC_W+1)'(delta);

    // Product of magnitude and frame step, from registered operands.
    assign prod = PROD_W'(mag_reg) * PROD_W'(num_reg);

    // One restoring division step: divisor is twice the frame span.
    assign dsr    = {den_reg, 1'b0};
    assign rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
    assign qbit   = (rem_sh >= {1'b0, dsr});

    // Apply the rounded step in the direction of the difference.
    assign from_ext = (VEC_W+2)'(from_reg);
    assign quo_ext  = (VEC_W+2)'({2'b00, dvd_reg[MAG_W-1:0]});
    assign sum      = neg_reg ? (from_ext - quo_ext) : (from_ext + quo_ext);
    assign result   = sum[VEC_W-1:0];
    assign done     = (state_reg == I_FIN);

    // Sequencer and datapath next values.
    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dvd_next   = dvd_reg;
        rem_next   = rem_reg;
        unique case (state_reg)
            I_IDLE: begin
                if (req.start) begin
                    state_next = I_MUL;
                end
            end
            I_MUL: begin
                dvd_next   = {prod, 1'b0} + DVD_W'(den_reg);
                rem_next   = '0;
                cnt_next   = '0;
                state_next = I_DIV;
            end
            I_DIV: begin
                rem_next = qbit ? DSR_W'(rem_sh - {1'b0, dsr}) : rem_sh[DSR_W-1:0];
                dvd_next = {dvd_reg[DVD_W-2:0], qbit};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                    state_next = I_FIN;
                end
            end
            I_FIN: begin
                state_next = I_IDLE;
            end
            default: begin
                state_next = I_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= I_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Operand and working registers.
    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        dvd_reg <= dvd_next;
        rem_reg <= rem_next;
        if (state_reg == I_IDLE && req.start) begin
            from_reg <= req.from_val;
            neg_reg  <= delta[VEC_W];
            mag_reg  <= delta_abs[MAG_W-1:0];
            num_reg  <= req.num;
            den_reg  <= req.den;
        end
    end

endmodule

@@ hdl/harmonic_phase_gap_fill.sv @@
// ============================================================================
// harmonic_phase_gap_fill: settles one harmonic's phase track across frames
// Takes one frame per request and emits each frame's phase vector once it is
// known, filling weak frames from their strong neighbours.
// ============================================================================
// Frames are taken one at a time. A frame that settles nothing is taken
// without leaving the idle state. Each result that is copied from a stored
// or incoming vector passes through the select and put states; each
// interpolated result takes longer, because the real and imaginary parts go
// one after the other through the shared interpolation unit (a multiply
// step, 23 restoring divide steps and a finishing step each). The block
// takes no new frame until the last result of the current frame is in the
// output register; that register lets the next frame be taken while the
// final result still waits. A strong frame after n weak ones therefore holds the input for all n interpolations.
module harmonic_phase_gap_fill
    import hpgf_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  hpgf_in_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output hpgf_out_t        m_data,
    input  logic             cfg_wr_en,
    input  logic [AMP_W-1:0] cfg_wr_data
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SEL   = 3'd1;
    localparam logic [2:0] S_RE    = 3'd2;
    localparam logic [2:0] S_IM_GO = 3'd3;
    localparam logic [2:0] S_IM    = 3'd4;
    localparam logic [2:0] S_PUT   = 3'd5;

    localparam logic [1:0] MODE_LEAD = 2'd0;
    localparam logic [1:0] MODE_FILL = 2'd1;
    localparam logic [1:0] MODE_HOLD = 2'd2;
    localparam logic [1:0] MODE_NONE = 2'd3;

    logic [2:0]              state_reg, state_next;
    logic [AMP_W-1:0]        thr_reg;
    logic [FRAME_W-1:0]      counter_reg;
    logic                    seen_reg;
    logic [FRAME_W-1:0]      anchor_frame_reg;
    logic signed [VEC_W-1:0] anchor_re_reg, anchor_im_reg;
    logic signed [VEC_W-1:0] first_re_reg, first_im_reg;

    logic [1:0]              mode_reg;
    logic [FRAME_W-1:0]      k_reg, end_reg, base_frame_reg;
    logic signed [VEC_W-1:0] vec_re_reg, vec_im_reg;
    logic signed [VEC_W-1:0] base_re_reg, base_im_reg;
    logic signed [VEC_W-1:0] res_re_reg, res_im_reg;

    logic                    m_valid_reg;
    hpgf_out_t               m_data_reg;

    logic                    s_accept;
    logic                    is_strong;
    logic                    last;
    logic                    emits;
    logic [1:0]              mode_new;
    logic                    is_end;
    logic                    need_div;
    logic                    out_free;
    logic                    load_out;
    logic signed [VEC_W-1:0] copy_re, copy_im;
    hpgf_div_req_t           div_req;
    logic                    div_done;
    logic signed [VEC_W-1:0] div_result;

    // Classify the incoming frame.
    assign s_ready   = (state_reg == S_IDLE);
    assign s_accept  = s_valid && s_ready;
    assign is_strong = (s_data.amplitude > thr_reg);
    assign last      = s_data.is_last_frame || (counter_reg >= FRAME_W'(FRAME_LIMIT - 1));
    assign emits     = is_strong || last;

    always_comb begin
        if (is_strong) begin
            mode_new = seen_reg ? MODE_FILL : MODE_LEAD;
        end else begin
            mode_new = seen_reg ? MODE_HOLD : MODE_NONE;
        end
    end

    // Value of the current frame when it needs no interpolation.
    assign is_end   = (k_reg == end_reg);
    assign need_div = (mode_reg == MODE_FILL) && !is_end;

    always_comb begin
        copy_re = vec_re_reg;
        copy_im = vec_im_reg;
        case (mode_reg)
            MODE_LEAD: begin
                if (!is_end && k_reg == '0) begin
                    copy_re = first_re_reg;
                    copy_im = first_im_reg;
                end
            end
            MODE_HOLD: begin
                copy_re = base_re_reg;
                copy_im = base_im_reg;
            end
            MODE_NONE: begin
                copy_re = '0;
                copy_im = Q15_ONE;
            end
            default: begin
                copy_re = vec_re_reg;
                copy_im = vec_im_reg;
            end
        endcase
    end

    // Request to the shared interpolation unit: real part first, then imaginary.
    always_comb begin
        div_req.start    = ((state_reg == S_SEL) && need_div) || (state_reg == S_IM_GO);
        div_req.from_val = (state_reg == S_IM_GO) ? base_im_reg : base_re_reg;
        div_req.to_val   = (state_reg == S_IM_GO) ? vec_im_reg : vec_re_reg;
        div_req.num      = k_reg - base_frame_reg;
        div_req.den      = end_reg - base_frame_reg;
    end

    hpgf_interp u_interp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .done    (div_done),
        .result  (div_result)
    );

    // Output register handshake.
    assign out_free = !m_valid_reg || m_ready;
    assign load_out = (state_reg == S_PUT) && out_free;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // Sequencer over the frames that the current request settles.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_accept && emits) begin
                    state_next = S_SEL;
                end
            end
            S_SEL: begin
                state_next = need_div ? S_RE : S_PUT;
            end
            S_RE: begin
                if (div_done) begin
                    state_next = S_IM_GO;
                end
            end
            S_IM_GO: begin
                state_next = S_IM;
            end
            S_IM: begin
                if (div_done) begin
                    state_next = S_PUT;
                end
            end
            S_PUT: begin
                if (out_free) begin
                    state_next = is_end ? S_IDLE : S_SEL;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state: sequencer, threshold, track state and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= S_IDLE;
            thr_reg          <= THRESHOLD_RESET;
            counter_reg      <= '0;
            seen_reg         <= 1'b0;
            anchor_frame_reg <= '0;
            anchor_re_reg    <= '0;
            anchor_im_reg    <= '0;
            first_re_reg     <= '0;
            first_im_reg     <= '0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                thr_reg <= cfg_wr_data;
            end
            if (s_accept) begin
                if (is_strong) begin
                    anchor_re_reg <= s_data.vector_re;
                    anchor_im_reg <= s_data.vector_im;
                end else if (counter_reg == '0) begin
                    first_re_reg <= s_data.vector_re;
                    first_im_reg <= s_data.vector_im;
                end
                // The last frame of a table clears the track for the next one.
                if (last) begin
                    counter_reg      <= '0;
                    seen_reg         <= 1'b0;
                    anchor_frame_reg <= '0;
                end else begin
                    counter_reg <= counter_reg + 1'b1;
                    if (is_strong) begin
                        seen_reg         <= 1'b1;
                        anchor_frame_reg <= counter_reg;
                    end
                end
            end
            if (load_out) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of the current request and the output payload.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            mode_reg       <= mode_new;
            end_reg        <= counter_reg;
            base_frame_reg <= anchor_frame_reg;
            base_re_reg    <= anchor_re_reg;
            base_im_reg    <= anchor_im_reg;
            vec_re_reg     <= s_data.vector_re;
            vec_im_reg     <= s_data.vector_im;
            k_reg          <= seen_reg ? anchor_frame_reg + 1'b1 : '0;
        end
        if (state_reg == S_SEL && !need_div) begin
            res_re_reg <= copy_re;
            res_im_reg <= copy_im;
        end
        if (state_reg == S_RE && div_done) begin
            res_re_reg <= div_result;
        end
        if (state_reg == S_IM && div_done) begin
            res_im_reg <= div_result;
        end
        if (load_out) begin
            m_data_reg.frame_number <= 6'(k_reg);
            m_data_reg.out_re       <= res_re_reg;
            m_data_reg.out_im       <= res_im_reg;
            m_data_reg.end_of_run   <= is_end;
            if (!is_end) begin
                k_reg <= k_reg + 1'b1;
            end
        end
    end

    // The interpolation unit only finishes while the sequencer waits for it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> (state_reg == S_RE || state_reg == S_IM))
        else $error("interpolation finished outside a wait state");

    // A result is never loaded over one that has not been taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        load_out |-> (!m_valid_reg || m_ready))
        else $error("pending result overwritten");

    // The frame index of a run never passes its final frame.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> (k_reg <= end_reg))
        else $error("frame index beyond end of run");

    // A weak frame that does not end the table leaves the block ready.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_accept && !emits) |=> (state_reg == S_IDLE))
        else $error("weak frame started a run");

    // Interpolation is only requested for frames strictly inside the gap.
    assert property (@(posedge aclk) disable iff (!aresetn)
        div_req.start |-> (k_reg > base_frame_reg && k_reg < end_reg))
        else $error("interpolation requested outside the gap");

endmodule
